// File: rtl/core/ofihp_pkg.sv
// ----------------------------------------------------------------------------
// ofihp_pkg
// Shared types, codes and constants of the file image header parser.
// ----------------------------------------------------------------------------
package ofihp_pkg;

  localparam int MAX_ARGS_DEF    = 16;
  localparam int KEY_LIMIT_DEF   = 32;
  localparam int VALUE_LIMIT_DEF = 64;
  localparam int LENGTH_BITS_DEF = 16;

  localparam int HDR_LEN = 12;

  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  localparam logic [2:0] ROLE_PREFIX  = 3'd0;
  localparam logic [2:0] ROLE_KEY     = 3'd1;
  localparam logic [2:0] ROLE_VALUE   = 3'd2;
  localparam logic [2:0] ROLE_DELIM   = 3'd3;
  localparam logic [2:0] ROLE_PAYLOAD = 3'd4;
  localparam logic [2:0] ROLE_DISCARD = 3'd5;

  localparam logic [1:0] STATUS_BUSY    = 2'd0;
  localparam logic [1:0] STATUS_SUCCESS = 2'd1;
  localparam logic [1:0] STATUS_ERROR   = 2'd2;

  typedef enum logic [6:0] {
    PH_PREFIX   = 7'b0000001,
    PH_ARGSTART = 7'b0000010,
    PH_KEY      = 7'b0000100,
    PH_VALUE    = 7'b0001000,
    PH_PAYLOAD  = 7'b0010000,
    PH_DONE     = 7'b0100000,
    PH_FAIL     = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [2:0] role;
    logic [3:0] slot;
    logic [5:0] pos;
    logic       kept;
    logic [1:0] status;
    logic       succ_inc;
    logic       err_inc;
  } res_t;

  function automatic logic [7:0] hdr_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h1B;
      4'd1:    b = 8'h5D;
      4'd2:    b = 8'h31;
      4'd3:    b = 8'h33;
      4'd4:    b = 8'h33;
      4'd5:    b = 8'h37;
      4'd6:    b = 8'h3B;
      4'd7:    b = 8'h46;
      4'd8:    b = 8'h69;
      4'd9:    b = 8'h6C;
      4'd10:   b = 8'h65;
      4'd11:   b = 8'h3D;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/core/ofihp_step.sv
// ----------------------------------------------------------------------------
// ofihp_step
// Per-byte parse logic: next parser state and the result fields of one byte.
// ----------------------------------------------------------------------------
module ofihp_step #(
  parameter int MAX_ARGS    = ofihp_pkg::MAX_ARGS_DEF,
  parameter int KEY_LIMIT   = ofihp_pkg::KEY_LIMIT_DEF,
  parameter int VALUE_LIMIT = ofihp_pkg::VALUE_LIMIT_DEF,
  parameter int LENGTH_BITS = ofihp_pkg::LENGTH_BITS_DEF,
  localparam int ARG_W = $clog2(MAX_ARGS + 1),
  localparam int FC_W  = $clog2((KEY_LIMIT > VALUE_LIMIT) ? KEY_LIMIT : VALUE_LIMIT)
) (
  input  logic [7:0]             byte_i,
  input  logic                   last_i,
  input  ofihp_pkg::phase_t      phase_i,
  input  logic [3:0]             pidx_i,
  input  logic [ARG_W-1:0]       acnt_i,
  input  logic [FC_W-1:0]        fcnt_i,
  input  logic                   kne_i,
  input  logic [LENGTH_BITS-1:0] bpos_i,
  input  logic [LENGTH_BITS-1:0] pstart_i,
  input  logic [LENGTH_BITS-1:0] pcnt_i,
  output ofihp_pkg::phase_t      phase_o,
  output logic [3:0]             pidx_o,
  output logic [ARG_W-1:0]       acnt_o,
  output logic [FC_W-1:0]        fcnt_o,
  output logic                   kne_o,
  output logic [LENGTH_BITS-1:0] bpos_o,
  output logic [LENGTH_BITS-1:0] pstart_o,
  output logic [LENGTH_BITS-1:0] pcnt_o,
  output ofihp_pkg::res_t        res_o,
  output logic [ARG_W-1:0]       acnt_res_o,
  output logic [LENGTH_BITS-1:0] pstart_res_o,
  output logic [LENGTH_BITS-1:0] pcnt_res_o
);

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  ofihp_pkg::phase_t      ph;
  logic [3:0]             pidx;
  logic [ARG_W-1:0]       acnt;
  logic [FC_W-1:0]        fc;
  logic                   kne;
  logic [LENGTH_BITS-1:0] pstart;
  logic [LENGTH_BITS-1:0] pcnt;
  logic [LENGTH_BITS-1:0] bpos_inc;
  logic                   key_path;
  logic                   is_term;
  logic [FC_W-1:0]        fc_k;
  logic                   kne_k;
  logic [8:0]             fc_ext;
  logic [7:0]             acnt_ext;
  logic                   char_hit;
  ofihp_pkg::res_t        res;

  assign bpos_inc = (bpos_i == LEN_MAX) ? bpos_i : bpos_i + 1'b1;
  assign is_term  = (byte_i == ofihp_pkg::CH_BEL) || (byte_i == ofihp_pkg::CH_ESC);

  always_comb begin
    ph       = phase_i;
    pidx     = pidx_i;
    acnt     = acnt_i;
    fc       = fcnt_i;
    kne      = kne_i;
    pstart   = pstart_i;
    pcnt     = pcnt_i;
    key_path = 1'b0;
    char_hit = 1'b0;
    fc_k     = fcnt_i;
    kne_k    = kne_i;
    res      = '0;
    res.role = ofihp_pkg::ROLE_DISCARD;

    case (phase_i)
      ofihp_pkg::PH_PREFIX: begin
        if (byte_i == ofihp_pkg::hdr_byte(pidx_i)) begin
          res.role = ofihp_pkg::ROLE_PREFIX;
          pidx     = pidx_i + 1'b1;
          if (pidx_i == 4'(ofihp_pkg::HDR_LEN - 1)) begin
            ph = ofihp_pkg::PH_ARGSTART;
          end
        end else begin
          ph          = ofihp_pkg::PH_FAIL;
          res.err_inc = 1'b1;
        end
      end
      ofihp_pkg::PH_ARGSTART: begin
        if (byte_i == ofihp_pkg::CH_COLON) begin
          res.role     = ofihp_pkg::ROLE_DELIM;
          ph           = ofihp_pkg::PH_PAYLOAD;
          pstart       = bpos_inc;
          pcnt         = '0;
          res.succ_inc = 1'b1;
        end else if (is_term || (acnt_i >= ARG_W'(MAX_ARGS))) begin
          ph          = ofihp_pkg::PH_FAIL;
          res.err_inc = 1'b1;
        end else begin
          key_path = 1'b1;
          fc_k     = '0;
          kne_k    = 1'b0;
        end
      end
      ofihp_pkg::PH_KEY: begin
        key_path = 1'b1;
      end
      ofihp_pkg::PH_VALUE: begin
        if (byte_i == ofihp_pkg::CH_SEMI) begin
          res.role = ofihp_pkg::ROLE_DELIM;
          acnt     = kne_i ? acnt_i + 1'b1 : acnt_i;
          kne      = 1'b0;
          fc       = '0;
          ph       = ofihp_pkg::PH_ARGSTART;
        end else if (byte_i == ofihp_pkg::CH_COLON) begin
          res.role     = ofihp_pkg::ROLE_DELIM;
          acnt         = kne_i ? acnt_i + 1'b1 : acnt_i;
          kne          = 1'b0;
          fc           = '0;
          ph           = ofihp_pkg::PH_PAYLOAD;
          pstart       = bpos_inc;
          pcnt         = '0;
          res.succ_inc = 1'b1;
        end else if (is_term) begin
          acnt        = kne_i ? acnt_i + 1'b1 : acnt_i;
          kne         = 1'b0;
          fc          = '0;
          ph          = ofihp_pkg::PH_FAIL;
          res.err_inc = 1'b1;
        end else begin
          res.role = ofihp_pkg::ROLE_VALUE;
          char_hit = 1'b1;
          if (fcnt_i < FC_W'(VALUE_LIMIT - 1)) begin
            fc       = fcnt_i + 1'b1;
            res.kept = 1'b1;
          end
        end
      end
      ofihp_pkg::PH_PAYLOAD: begin
        if (is_term) begin
          res.role = ofihp_pkg::ROLE_DELIM;
          ph       = ofihp_pkg::PH_DONE;
        end else begin
          res.role = ofihp_pkg::ROLE_PAYLOAD;
          pcnt     = (pcnt_i == LEN_MAX) ? pcnt_i : pcnt_i + 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (key_path) begin
      fc  = fc_k;
      kne = kne_k;
      if (byte_i == ofihp_pkg::CH_EQ) begin
        res.role = ofihp_pkg::ROLE_DELIM;
        ph       = ofihp_pkg::PH_VALUE;
        fc       = '0;
      end else if (byte_i == ofihp_pkg::CH_SEMI) begin
        res.role = ofihp_pkg::ROLE_DELIM;
        acnt     = kne_k ? acnt_i + 1'b1 : acnt_i;
        kne      = 1'b0;
        fc       = '0;
        ph       = ofihp_pkg::PH_ARGSTART;
      end else if (byte_i == ofihp_pkg::CH_COLON) begin
        res.role     = ofihp_pkg::ROLE_DELIM;
        acnt         = kne_k ? acnt_i + 1'b1 : acnt_i;
        kne          = 1'b0;
        fc           = '0;
        ph           = ofihp_pkg::PH_PAYLOAD;
        pstart       = bpos_inc;
        pcnt         = '0;
        res.succ_inc = 1'b1;
      end else begin
        res.role = ofihp_pkg::ROLE_KEY;
        char_hit = 1'b1;
        kne      = 1'b1;
        ph       = ofihp_pkg::PH_KEY;
        if (fc_k < FC_W'(KEY_LIMIT - 1)) begin
          fc       = fc_k + 1'b1;
          res.kept = 1'b1;
        end
      end
    end

    acnt_ext = 8'(acnt_i);
    fc_ext   = 9'(fc);
    if (char_hit) begin
      res.slot = acnt_ext[3:0];
      res.pos  = (fc_ext > 9'd63) ? 6'd63 : fc_ext[5:0];
    end

    if (last_i && (ph != ofihp_pkg::PH_PAYLOAD) && (ph != ofihp_pkg::PH_DONE) &&
        (ph != ofihp_pkg::PH_FAIL)) begin
      ph          = ofihp_pkg::PH_FAIL;
      res.err_inc = 1'b1;
    end

    if (ph == ofihp_pkg::PH_FAIL) begin
      res.status = ofihp_pkg::STATUS_ERROR;
    end else if ((ph == ofihp_pkg::PH_PAYLOAD) || (ph == ofihp_pkg::PH_DONE)) begin
      res.status = ofihp_pkg::STATUS_SUCCESS;
    end else begin
      res.status = ofihp_pkg::STATUS_BUSY;
    end
  end

  assign res_o        = res;
  assign acnt_res_o   = acnt;
  assign pstart_res_o = pstart;
  assign pcnt_res_o   = pcnt;

  assign phase_o  = last_i ? ofihp_pkg::PH_PREFIX : ph;
  assign pidx_o   = last_i ? 4'd0 : pidx;
  assign acnt_o   = last_i ? '0 : acnt;
  assign fcnt_o   = last_i ? '0 : fc;
  assign kne_o    = last_i ? 1'b0 : kne;
  assign bpos_o   = last_i ? '0 : bpos_inc;
  assign pstart_o = last_i ? '0 : pstart;
  assign pcnt_o   = last_i ? '0 : pcnt;

endmodule

// File: rtl/core/osc_file_image_header_parser.sv
// ----------------------------------------------------------------------------
// osc_file_image_header_parser
// Byte-serial parser for the header of a terminal inline file escape sequence.
//
//   Channel  Direction  Transaction
//   in_      input      one buffer byte and its end-of-buffer flag
//   out_     output     role, slot, position and running status of that byte
//
// One byte is taken per cycle while in_stall is low; each byte passes an
// input register and then a result register, from which its result is
// driven on out_. The rate is set by the parser state update between the
// two, which is registered together with the result.
// Reset clears the parser state, both totals and both valid flags.
// A stall on the result side holds the result register; while a byte also
// waits in the input register, in_stall is high in that same cycle.
// ----------------------------------------------------------------------------
module osc_file_image_header_parser #(
  parameter int MAX_ARGS    = ofihp_pkg::MAX_ARGS_DEF,
  parameter int KEY_LIMIT   = ofihp_pkg::KEY_LIMIT_DEF,
  parameter int VALUE_LIMIT = ofihp_pkg::VALUE_LIMIT_DEF,
  parameter int LENGTH_BITS = ofihp_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_byte_role,
  output logic [3:0]  out_arg_slot,
  output logic [5:0]  out_char_position,
  output logic        out_char_kept,
  output logic [1:0]  out_parse_status,
  output logic [4:0]  out_args_found,
  output logic [15:0] out_payload_offset,
  output logic [15:0] out_payload_length,
  output logic [31:0] out_success_total,
  output logic [31:0] out_error_total
);

  localparam int ARG_W = $clog2(MAX_ARGS + 1);
  localparam int FC_W  = $clog2((KEY_LIMIT > VALUE_LIMIT) ? KEY_LIMIT : VALUE_LIMIT);
  localparam int EXT_W = LENGTH_BITS + 16;

  logic                   s1_valid_r;
  logic [7:0]             s1_byte_r;
  logic                   s1_last_r;
  logic                   out_free;
  logic                   fire;

  ofihp_pkg::phase_t      phase_r, phase_nxt;
  logic [3:0]             pidx_r, pidx_nxt;
  logic [ARG_W-1:0]       acnt_r, acnt_nxt;
  logic [FC_W-1:0]        fcnt_r, fcnt_nxt;
  logic                   kne_r, kne_nxt;
  logic [LENGTH_BITS-1:0] bpos_r, bpos_nxt;
  logic [LENGTH_BITS-1:0] pstart_r, pstart_nxt;
  logic [LENGTH_BITS-1:0] pcnt_r, pcnt_nxt;
  logic [31:0]            succ_r, succ_nxt;
  logic [31:0]            err_r, err_nxt;

  ofihp_pkg::res_t        res;
  logic [ARG_W-1:0]       acnt_res;
  logic [LENGTH_BITS-1:0] pstart_res;
  logic [LENGTH_BITS-1:0] pcnt_res;
  logic [7:0]             acnt_ext;
  logic [EXT_W-1:0]       pstart_ext;
  logic [EXT_W-1:0]       pcnt_ext;

  logic                   out_valid_r;
  ofihp_pkg::res_t        out_res_r;
  logic [4:0]             out_args_r;
  logic [15:0]            out_poff_r;
  logic [15:0]            out_plen_r;
  logic [31:0]            out_succ_r;
  logic [31:0]            out_err_r;

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_byte_value;
      s1_last_r <= in_is_last;
    end
  end

  ofihp_step #(
    .MAX_ARGS    (MAX_ARGS),
    .KEY_LIMIT   (KEY_LIMIT),
    .VALUE_LIMIT (VALUE_LIMIT),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_step (
    .byte_i       (s1_byte_r),
    .last_i       (s1_last_r),
    .phase_i      (phase_r),
    .pidx_i       (pidx_r),
    .acnt_i       (acnt_r),
    .fcnt_i       (fcnt_r),
    .kne_i        (kne_r),
    .bpos_i       (bpos_r),
    .pstart_i     (pstart_r),
    .pcnt_i       (pcnt_r),
    .phase_o      (phase_nxt),
    .pidx_o       (pidx_nxt),
    .acnt_o       (acnt_nxt),
    .fcnt_o       (fcnt_nxt),
    .kne_o        (kne_nxt),
    .bpos_o       (bpos_nxt),
    .pstart_o     (pstart_nxt),
    .pcnt_o       (pcnt_nxt),
    .res_o        (res),
    .acnt_res_o   (acnt_res),
    .pstart_res_o (pstart_res),
    .pcnt_res_o   (pcnt_res)
  );

  assign succ_nxt   = succ_r + 32'(res.succ_inc);
  assign err_nxt    = err_r + 32'(res.err_inc);
  assign acnt_ext   = 8'(acnt_res);
  assign pstart_ext = EXT_W'(pstart_res);
  assign pcnt_ext   = EXT_W'(pcnt_res);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= ofihp_pkg::PH_PREFIX;
      pidx_r   <= '0;
      acnt_r   <= '0;
      fcnt_r   <= '0;
      kne_r    <= 1'b0;
      bpos_r   <= '0;
      pstart_r <= '0;
      pcnt_r   <= '0;
      succ_r   <= '0;
      err_r    <= '0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      pidx_r   <= pidx_nxt;
      acnt_r   <= acnt_nxt;
      fcnt_r   <= fcnt_nxt;
      kne_r    <= kne_nxt;
      bpos_r   <= bpos_nxt;
      pstart_r <= pstart_nxt;
      pcnt_r   <= pcnt_nxt;
      succ_r   <= succ_nxt;
      err_r    <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r  <= res;
      out_args_r <= acnt_ext[4:0];
      out_poff_r <= pstart_ext[15:0];
      out_plen_r <= pcnt_ext[15:0];
      out_succ_r <= succ_nxt;
      out_err_r  <= err_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte_role      = out_res_r.role;
  assign out_arg_slot       = out_res_r.slot;
  assign out_char_position  = out_res_r.pos;
  assign out_char_kept      = out_res_r.kept;
  assign out_parse_status   = out_res_r.status;
  assign out_args_found     = out_args_r;
  assign out_payload_offset = out_poff_r;
  assign out_payload_length = out_plen_r;
  assign out_success_total  = out_succ_r;
  assign out_error_total    = out_err_r;

  a_prefix_range: assert property (@(posedge clk) disable iff (!rst_n)
    pidx_r <= 4'(ofihp_pkg::HDR_LEN))
    else $error("prefix index beyond header length");

  a_args_range: assert property (@(posedge clk) disable iff (!rst_n)
    acnt_r <= ARG_W'(MAX_ARGS))
    else $error("argument count beyond its limit");

  a_succ_step: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.succ_inc |=> succ_r == $past(succ_r) + 32'd1)
    else $error("success total did not advance on a colon");

  a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.role == ofihp_pkg::ROLE_PAYLOAD) |->
      out_res_r.status == ofihp_pkg::STATUS_SUCCESS)
    else $error("payload byte reported without success status");

endmodule

// File: tb/ofihp_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ofihp_result_checker
// Predicts and checks every result of the file image header parser.
//
// The checker watches both channels. For each accepted input transaction it
// runs its own model of the header parser and queues the expected result. Each
// accepted result transaction is compared, field by field, with the oldest
// entry of that queue. The number of mismatches and the number of results still
// outstanding are handed to the testbench top.
// ----------------------------------------------------------------------------
module ofihp_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_is_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_byte_role,
  input  logic [3:0]  out_arg_slot,
  input  logic [5:0]  out_char_position,
  input  logic        out_char_kept,
  input  logic [1:0]  out_parse_status,
  input  logic [4:0]  out_args_found,
  input  logic [15:0] out_payload_offset,
  input  logic [15:0] out_payload_length,
  input  logic [31:0] out_success_total,
  input  logic [31:0] out_error_total,
  output int          mismatch_count,
  output int          results_pending
);

  localparam logic [8*ofihp_pkg::HDR_LEN-1:0] OSC_HEADER =
    {ofihp_pkg::CH_ESC, "]1337;File="};

  typedef struct packed {
    logic [2:0]  role;
    logic [3:0]  slot;
    logic [5:0]  position;
    logic        kept;
    logic [1:0]  status;
    logic [4:0]  args_found;
    logic [15:0] pay_offset;
    logic [15:0] pay_length;
    logic [31:0] successes;
    logic [31:0] errors;
  } byte_report_t;

  ofihp_pkg::phase_t phase;
  logic [3:0]  prefix_idx;
  logic [4:0]  keys_counted;
  logic [5:0]  field_len;
  logic        key_has_chars;
  logic [15:0] byte_pos;
  logic [15:0] payload_begin;
  logic [15:0] payload_bytes;
  logic [31:0] ok_total;
  logic [31:0] bad_total;

  byte_report_t expected_reports[$];

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic void clear_buffer();
    phase         = ofihp_pkg::PH_PREFIX;
    prefix_idx    = '0;
    keys_counted  = '0;
    field_len     = '0;
    key_has_chars = 1'b0;
    byte_pos      = '0;
    payload_begin = '0;
    payload_bytes = '0;
  endfunction

  function automatic void reject_buffer();
    phase     = ofihp_pkg::PH_FAIL;
    bad_total = bad_total + 32'd1;
  endfunction

  function automatic void close_field();
    if (key_has_chars) keys_counted = keys_counted + 5'd1;
    key_has_chars = 1'b0;
    field_len     = '0;
  endfunction

  function automatic void open_payload();
    phase         = ofihp_pkg::PH_PAYLOAD;
    payload_begin = sat_inc(byte_pos);
    payload_bytes = '0;
    ok_total      = ok_total + 32'd1;
  endfunction

  function automatic byte_report_t parse_byte(input logic [7:0] b, input logic last);
    byte_report_t r;
    logic taken;
    r = '0;
    r.role = ofihp_pkg::ROLE_DISCARD;
    taken = 1'b0;
    if (phase == ofihp_pkg::PH_PREFIX) begin
      taken = 1'b1;
      if (prefix_idx < ofihp_pkg::HDR_LEN &&
          b == OSC_HEADER[8*(ofihp_pkg::HDR_LEN-1-int'(prefix_idx)) +: 8]) begin
        r.role = ofihp_pkg::ROLE_PREFIX;
        prefix_idx = prefix_idx + 4'd1;
        if (prefix_idx >= ofihp_pkg::HDR_LEN) phase = ofihp_pkg::PH_ARGSTART;
      end else begin
        reject_buffer();
      end
    end else if (phase == ofihp_pkg::PH_ARGSTART) begin
      if (b == ofihp_pkg::CH_COLON) begin
        taken = 1'b1;
        r.role = ofihp_pkg::ROLE_DELIM;
        open_payload();
      end else if (b == ofihp_pkg::CH_BEL || b == ofihp_pkg::CH_ESC ||
                   keys_counted >= ofihp_pkg::MAX_ARGS_DEF) begin
        taken = 1'b1;
        reject_buffer();
      end else begin
        phase = ofihp_pkg::PH_KEY;
        field_len = '0;
        key_has_chars = 1'b0;
      end
    end

    if (!taken && phase == ofihp_pkg::PH_KEY) begin
      taken = 1'b1;
      if (b == ofihp_pkg::CH_EQ) begin
        r.role = ofihp_pkg::ROLE_DELIM;
        phase = ofihp_pkg::PH_VALUE;
        field_len = '0;
      end else if (b == ofihp_pkg::CH_SEMI) begin
        r.role = ofihp_pkg::ROLE_DELIM;
        close_field();
        phase = ofihp_pkg::PH_ARGSTART;
      end else if (b == ofihp_pkg::CH_COLON) begin
        r.role = ofihp_pkg::ROLE_DELIM;
        close_field();
        open_payload();
      end else begin
        r.role = ofihp_pkg::ROLE_KEY;
        r.slot = keys_counted[3:0];
        key_has_chars = 1'b1;
        if (field_len < ofihp_pkg::KEY_LIMIT_DEF - 1) begin
          field_len = field_len + 6'd1;
          r.kept = 1'b1;
        end
        r.position = field_len;
      end
    end else if (!taken && phase == ofihp_pkg::PH_VALUE) begin
      taken = 1'b1;
      if (b == ofihp_pkg::CH_SEMI) begin
        r.role = ofihp_pkg::ROLE_DELIM;
        close_field();
        phase = ofihp_pkg::PH_ARGSTART;
      end else if (b == ofihp_pkg::CH_COLON) begin
        r.role = ofihp_pkg::ROLE_DELIM;
        close_field();
        open_payload();
      end else if (b == ofihp_pkg::CH_BEL || b == ofihp_pkg::CH_ESC) begin
        close_field();
        reject_buffer();
      end else begin
        r.role = ofihp_pkg::ROLE_VALUE;
        r.slot = keys_counted[3:0];
        if (field_len < ofihp_pkg::VALUE_LIMIT_DEF - 1) begin
          field_len = field_len + 6'd1;
          r.kept = 1'b1;
        end
        r.position = field_len;
      end
    end else if (!taken && phase == ofihp_pkg::PH_PAYLOAD) begin
      if (b == ofihp_pkg::CH_BEL || b == ofihp_pkg::CH_ESC) begin
        r.role = ofihp_pkg::ROLE_DELIM;
        phase = ofihp_pkg::PH_DONE;
      end else begin
        r.role = ofihp_pkg::ROLE_PAYLOAD;
        payload_bytes = sat_inc(payload_bytes);
      end
    end

    if (last && phase != ofihp_pkg::PH_PAYLOAD && phase != ofihp_pkg::PH_DONE &&
        phase != ofihp_pkg::PH_FAIL) reject_buffer();

    if (phase == ofihp_pkg::PH_FAIL) r.status = ofihp_pkg::STATUS_ERROR;
    else if (phase == ofihp_pkg::PH_PAYLOAD || phase == ofihp_pkg::PH_DONE)
      r.status = ofihp_pkg::STATUS_SUCCESS;
    else r.status = ofihp_pkg::STATUS_BUSY;

    r.args_found = keys_counted;
    r.pay_offset = payload_begin;
    r.pay_length = payload_bytes;
    r.successes  = ok_total;
    r.errors     = bad_total;

    byte_pos = sat_inc(byte_pos);
    if (last) clear_buffer();
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) report_mismatch($sformatf("%s mismatch: expected %0d, got %0d",
                                                name, want, got));
  endtask

  always @(posedge clk) begin
    byte_report_t want;
    if (!rst_n) begin
      clear_buffer();
      ok_total = '0;
      bad_total = '0;
      expected_reports.delete();
      mismatch_count = 0;
      results_pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          report_mismatch("result transaction with no expected result");
        end else begin
          want = expected_reports.pop_front();
          check_field("byte_role", want.role, out_byte_role);
          check_field("arg_slot", want.slot, out_arg_slot);
          check_field("char_position", want.position, out_char_position);
          check_field("char_kept", want.kept, out_char_kept);
          check_field("parse_status", want.status, out_parse_status);
          check_field("args_found", want.args_found, out_args_found);
          check_field("payload_offset", want.pay_offset, out_payload_offset);
          check_field("payload_length", want.pay_length, out_payload_length);
          check_field("success_total", want.successes, out_success_total);
          check_field("error_total", want.errors, out_error_total);
        end
      end
      if (in_valid && !in_stall) expected_reports.push_back(parse_byte(in_byte_value, in_is_last));
      results_pending <= expected_reports.size();
    end
  end

endmodule

// File: tb/tb_osc_file_image_header_parser.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_osc_file_image_header_parser
// Stimulus and verdict for the file image header parser.
//
// Directed buffers cover good headers, prefix errors, early ends, empty and
// odd keys, stray BEL and ESC bytes, the argument limit and truncation.
// Random buffers follow, mostly well-formed headers with random content and
// some noise. The sender works in bursts, the receiver stalls on its own
// pattern, and a separate checker compares every result.
// ----------------------------------------------------------------------------
module tb_osc_file_image_header_parser;

  localparam int          RANDOM_ITEMS = 1050;
  localparam logic [31:0] CYCLE_LIMIT  = 32'd2_000_000;
  localparam logic [8*ofihp_pkg::HDR_LEN-1:0] OSC_HEADER =
    {ofihp_pkg::CH_ESC, "]1337;File="};

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte_value;
  logic        in_is_last;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_byte_role;
  logic [3:0]  out_arg_slot;
  logic [5:0]  out_char_position;
  logic        out_char_kept;
  logic [1:0]  out_parse_status;
  logic [4:0]  out_args_found;
  logic [15:0] out_payload_offset;
  logic [15:0] out_payload_length;
  logic [31:0] out_success_total;
  logic [31:0] out_error_total;

  int          mismatch_count;
  int          results_pending;
  logic [31:0] cycle_count = '0;
  int          stall_mode = 0;
  int          burst_left = 0;
  int          items_sent = 0;
  logic [7:0]  buffer_q[$];

  osc_file_image_header_parser dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte_value     (in_byte_value),
    .in_is_last        (in_is_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte_role     (out_byte_role),
    .out_arg_slot      (out_arg_slot),
    .out_char_position (out_char_position),
    .out_char_kept     (out_char_kept),
    .out_parse_status  (out_parse_status),
    .out_args_found    (out_args_found),
    .out_payload_offset(out_payload_offset),
    .out_payload_length(out_payload_length),
    .out_success_total (out_success_total),
    .out_error_total   (out_error_total)
  );

  ofihp_result_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte_value     (in_byte_value),
    .in_is_last        (in_is_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte_role     (out_byte_role),
    .out_arg_slot      (out_arg_slot),
    .out_char_position (out_char_position),
    .out_char_kept     (out_char_kept),
    .out_parse_status  (out_parse_status),
    .out_args_found    (out_args_found),
    .out_payload_offset(out_payload_offset),
    .out_payload_length(out_payload_length),
    .out_success_total (out_success_total),
    .out_error_total   (out_error_total),
    .mismatch_count    (mismatch_count),
    .results_pending   (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 32'd1;
    if (cycle_count[5:0] == 6'd0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 7) == 0);
      2:       out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= (cycle_count[2:0] < 3'd3);
    endcase
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] value, input logic last);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    in_valid      <= 1'b1;
    in_byte_value <= value;
    in_is_last    <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) burst_left--;
    items_sent++;
  endtask

  task automatic send_buffer();
    for (int i = 0; i < buffer_q.size(); i++) send_byte(buffer_q[i], i == buffer_q.size() - 1);
    buffer_q.delete();
  endtask

  task automatic push_header(input int count);
    for (int i = 0; i < count; i++)
      buffer_q.push_back(OSC_HEADER[8*(ofihp_pkg::HDR_LEN-1-i) +: 8]);
  endtask

  task automatic push_string(input string s);
    for (int i = 0; i < s.len(); i++) buffer_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] c;
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    do c = 8'($urandom_range(8'h20, 8'h7E));
    while (c == ofihp_pkg::CH_COLON || c == ofihp_pkg::CH_SEMI || c == ofihp_pkg::CH_EQ);
    return c;
  endfunction

  task automatic push_text(input int count);
    repeat (count) buffer_q.push_back(text_byte());
  endtask

  task automatic build_header_buffer();
    int n_args;
    int cut;
    push_header(ofihp_pkg::HDR_LEN);
    if ($urandom_range(0, 19) == 0)
      buffer_q[$urandom_range(0, ofihp_pkg::HDR_LEN - 1)] = 8'($urandom_range(0, 255));
    n_args = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 5);
    for (int a = 0; a < n_args; a++) begin
      push_text(($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 6));
      if ($urandom_range(0, 4) != 0) begin
        buffer_q.push_back(ofihp_pkg::CH_EQ);
        push_text(($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8));
      end
      if (a < n_args - 1 || $urandom_range(0, 3) == 0) buffer_q.push_back(ofihp_pkg::CH_SEMI);
    end
    case ($urandom_range(0, 9))
      0:       ;
      1:       buffer_q.push_back($urandom_range(0, 1) ? ofihp_pkg::CH_BEL : ofihp_pkg::CH_ESC);
      default: buffer_q.push_back(ofihp_pkg::CH_COLON);
    endcase
    repeat ($urandom_range(0, 12)) buffer_q.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 2) != 0) begin
      buffer_q.push_back($urandom_range(0, 1) ? ofihp_pkg::CH_BEL : ofihp_pkg::CH_ESC);
      repeat ($urandom_range(0, 3)) buffer_q.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, buffer_q.size());
      while (buffer_q.size() > cut) void'(buffer_q.pop_back());
    end
  endtask

  initial begin
    int random_start;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_byte_value <= '0;
    in_is_last    <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed buffers.
    push_header(ofihp_pkg::HDR_LEN);
    push_string(":AB");
    buffer_q.push_back(ofihp_pkg::CH_BEL);
    push_string("zz");
    send_buffer();

    buffer_q.push_back(8'hFF);
    send_buffer();

    push_header(5);
    push_string("Qrest");
    send_buffer();

    push_header(8);
    send_buffer();

    push_header(ofihp_pkg::HDR_LEN);
    push_string("name=abc;;=v;");
    buffer_q.push_back(8'h00);
    buffer_q.push_back(ofihp_pkg::CH_BEL);
    buffer_q.push_back(ofihp_pkg::CH_ESC);
    push_string("=q;size=12:PAY");
    buffer_q.push_back(ofihp_pkg::CH_ESC);
    send_buffer();

    push_header(ofihp_pkg::HDR_LEN);
    push_string("a=1;");
    buffer_q.push_back(ofihp_pkg::CH_BEL);
    push_string("x");
    send_buffer();

    push_header(ofihp_pkg::HDR_LEN);
    buffer_q.push_back(ofihp_pkg::CH_ESC);
    send_buffer();

    push_header(ofihp_pkg::HDR_LEN);
    push_string("k=va");
    buffer_q.push_back(ofihp_pkg::CH_ESC);
    push_string("x");
    send_buffer();

    push_header(ofihp_pkg::HDR_LEN);
    repeat (ofihp_pkg::MAX_ARGS_DEF) push_string("a;");
    push_string(":p");
    send_buffer();

    push_header(ofihp_pkg::HDR_LEN);
    repeat (ofihp_pkg::MAX_ARGS_DEF) push_string("b=1;");
    push_string("c");
    send_buffer();

    push_header(ofihp_pkg::HDR_LEN);
    repeat (ofihp_pkg::KEY_LIMIT_DEF + 3) buffer_q.push_back(8'hA5);
    buffer_q.push_back(ofihp_pkg::CH_EQ);
    repeat (ofihp_pkg::VALUE_LIMIT_DEF + 2) buffer_q.push_back(8'h5A);
    buffer_q.push_back(ofihp_pkg::CH_COLON);
    send_buffer();

    push_header(ofihp_pkg::HDR_LEN);
    push_string("k=v");
    send_buffer();

    push_header(ofihp_pkg::HDR_LEN);
    push_string("key:");
    buffer_q.push_back(ofihp_pkg::CH_BEL);
    send_buffer();

    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 6) != 0) begin
        build_header_buffer();
      end else begin
        if ($urandom_range(0, 1)) push_header($urandom_range(1, ofihp_pkg::HDR_LEN));
        repeat ($urandom_range(1, 16)) buffer_q.push_back(8'($urandom_range(0, 255)));
      end
      send_buffer();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/ofihp_pkg.sv
rtl/core/ofihp_step.sv
rtl/core/osc_file_image_header_parser.sv
tb/ofihp_result_checker.sv
tb/tb_osc_file_image_header_parser.sv
